@@ hw/rtl/byte_run_length_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Byte run-length encoder assertion macros
// Shared concurrent assertion shorthands; the enclosing module must have
// clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef BYTE_RUN_LENGTH_ENCODER_DEFINES_SVH
`define BYTE_RUN_LENGTH_ENCODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define BRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define BRLE_ASSERT_NEVER(lbl, expr, msg) \
  `BRLE_ASSERT(lbl, !(expr), msg)

`endif

@@ hw/rtl/brle_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte run-length encoder package
// Request and result types and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package brle_pkg;

  // Longest run one pair can carry.
  localparam logic [7:0] RUN_MAX = 8'd255;

  // One input byte with its chunk end flag.
  typedef struct packed {
    logic [7:0] pixel_value;
    logic       chunk_end;
  } pixel_req_t;

  // One emitted (count, value) pair.
  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] run_value;
    logic       chunk_done;
  } run_pair_t;

  // Pairs produced by one request: num is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] num;
    run_pair_t  first;
    run_pair_t  second;
  } pair_push_t;

endpackage

@@ hw/rtl/brle_core.sv @@
// ----------------------------------------------------------------------------
// Byte run-length encoder run tracker
// Holds the open run and turns one request into zero, one or two pairs.
// ----------------------------------------------------------------------------
module brle_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  brle_pkg::pixel_req_t req_i,
  output brle_pkg::pair_push_t push_o
);
  import brle_pkg::*;

  logic       run_open_q, run_open_d;
  logic [7:0] held_value_q, held_value_d;
  logic [7:0] held_count_q, held_count_d;
  logic       brk;
  logic [7:0] new_count;
  run_pair_t  broken_pair;
  run_pair_t  final_pair;

  // Break the run on a different byte or a full run.
  assign brk = run_open_q &&
               !((req_i.pixel_value == held_value_q) && (held_count_q != RUN_MAX));

  assign new_count = (!run_open_q || brk) ? 8'd1 : held_count_q + 8'd1;

  always_comb begin
    broken_pair.run_length = held_count_q;
    broken_pair.run_value  = held_value_q;
    broken_pair.chunk_done = 1'b0;
    final_pair.run_length  = new_count;
    final_pair.run_value   = req_i.pixel_value;
    final_pair.chunk_done  = 1'b1;
  end

  always_comb begin
    push_o.first  = brk ? broken_pair : final_pair;
    push_o.second = final_pair;
    push_o.num    = en_i ? ({1'b0, brk} + {1'b0, req_i.chunk_end}) : 2'd0;
  end

  always_comb begin
    run_open_d   = run_open_q;
    held_value_d = held_value_q;
    held_count_d = held_count_q;
    if (en_i) begin
      run_open_d   = !req_i.chunk_end;
      held_value_d = req_i.pixel_value;
      held_count_d = new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      held_value_q <= 8'd0;
      held_count_q <= 8'd0;
    end else begin
      run_open_q   <= run_open_d;
      held_value_q <= held_value_d;
      held_count_q <= held_count_d;
    end
  end

endmodule

@@ hw/rtl/brle_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Byte run-length encoder result queue
// Four-entry pair queue: takes up to two pairs per cycle, hands out one.
// ----------------------------------------------------------------------------
`include "byte_run_length_encoder_defines.svh"

module brle_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brle_pkg::pair_push_t push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output brle_pkg::run_pair_t  out_pair_o
);
  import brle_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  run_pair_t              slot_q [Depth];
  logic [AddrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [AddrW-1:0]       wr_next;
  logic                   pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_pair_o  = slot_q[rd_ptr_q];
  // Room for a worst-case request of two pairs.
  assign room_o      = (count_q <= CntW'(Depth - 2));
  assign wr_next     = wr_ptr_q + AddrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + AddrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + AddrW'(pop);
    count_d  = count_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      slot_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      slot_q[wr_next] <= push_i.second;
    end
  end

  `BRLE_ASSERT(a_count_bound, count_q <= CntW'(Depth), "pair queue overflow")
  `BRLE_ASSERT_NEVER(a_num_legal, push_i.num == 2'd3, "more than two pairs per request")
  `BRLE_ASSERT(a_count_track, count_q == $past(count_d), "pair queue count lost track")
  `BRLE_ASSERT_NEVER(a_push_room, (push_i.num == 2'd2) && !room_o, "two pairs without room")

endmodule

@@ hw/rtl/byte_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// Byte run-length encoder
// Turns a byte stream with chunk end marks into (run length, value) pairs.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_req_i  (pixel, chunk end)
//   out     | output    | out_valid_o/out_ready_i| out_pair_o (length, value, done)
//
// One request per cycle is accepted into an input register while that register
// is empty or drains; once the queue has room, the run tracker folds it into
// the open run and pushes 0, 1 or 2 pairs into a four-entry result queue.
// The input register drains only while the queue has room for two pairs, as
// a chunk end that breaks a run pushes two; input stalls only when the
// output side is held off.
// Reset closes any open run and empties the input register and the queue.
// ----------------------------------------------------------------------------
module byte_run_length_encoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  brle_pkg::pixel_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output brle_pkg::run_pair_t   out_pair_o
);
  import brle_pkg::*;

  logic       stage_valid_q, stage_valid_d;
  pixel_req_t stage_req_q;
  logic       room;
  logic       drain;
  pair_push_t push;

  // Advance the staged request when the queue can take its worst case.
  assign drain      = stage_valid_q && room;
  // Take a new request when the stage is empty or empties this cycle.
  assign in_ready_o = !stage_valid_q || room;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_ready_o) begin
      stage_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  // Hold the payload unless a new request is taken.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_req_q <= in_req_i;
    end
  end

  brle_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (drain),
    .req_i  (stage_req_q),
    .push_o (push)
  );

  brle_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pair_o  (out_pair_o)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Byte run-length encoder testbench
// Sends byte streams with chunk end marks through the encoder and checks
// every emitted (length, value, done) pair against an in-bench run tracker.
// Both handshakes idle at random, the output side holds off long enough to
// stall the input once, and the run ends on a steady stream.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brle_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int LONG_HOLD    = 64;    // long output hold-off, in cycles
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 8;     // extra cycles after the last pair

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  pixel_req_t in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  run_pair_t  out_pair_o;

  byte_run_length_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pair_o  (out_pair_o)
  );

  // Run tracker state, mirrored from the encoder's behavior.
  logic       run_open_q;
  logic [7:0] held_value_q;
  logic [7:0] held_count_q;

  // Pairs predicted but not yet seen on the output, oldest first.
  run_pair_t pending_pairs[$];

  int unsigned mismatch_count;
  int unsigned pixels_sent;
  int unsigned idle_cycles;

  // Idling controls for the sender (gap_en) and the receiver (stall_en, long_hold_pending).
  bit gap_en;
  bit stall_en;
  bit long_hold_pending;

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Run tracker
  // --------------------------------------------------------------------------

  // Queue the currently held run as an expected pair.
  function automatic void emit_held_run(logic done);
    run_pair_t pair;
    pair.run_length = held_count_q;
    pair.run_value  = held_value_q;
    pair.chunk_done = done;
    pending_pairs = {pending_pairs, pair};
  endfunction

  // Fold one accepted request into the open run and queue the pairs it
  // causes: a break emits the old run, a chunk end then flushes and closes.
  function automatic void fold_pixel(pixel_req_t req);
    if (!run_open_q) begin
      // first byte of a chunk opens a run of one
      held_value_q = req.pixel_value;
      held_count_q = 8'd1;
      run_open_q   = 1'b1;
    end else if (req.pixel_value == held_value_q && held_count_q != RUN_MAX) begin
      held_count_q = held_count_q + 8'd1;
    end else begin
      // different byte, or a full run even on an equal byte
      emit_held_run(1'b0);
      held_value_q = req.pixel_value;
      held_count_q = 8'd1;
    end
    if (req.chunk_end) begin
      emit_held_run(1'b1);
      run_open_q = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sample both channels at the rising edge. Check the output first: a pair
  // leaving now can never belong to a request accepted at the same edge.
  always @(posedge clk_i) begin : pair_monitor
    run_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_pairs.size() == 0) begin
          flag_mismatch($sformatf("unexpected pair len %0d val %0d done %0b",
                                  out_pair_o.run_length, out_pair_o.run_value,
                                  out_pair_o.chunk_done));
        end else begin
          want = pending_pairs.pop_front();
          if (out_pair_o.run_length !== want.run_length)
            flag_mismatch($sformatf("run_length got %0d want %0d",
                                    out_pair_o.run_length, want.run_length));
          if (out_pair_o.run_value !== want.run_value)
            flag_mismatch($sformatf("run_value got %0d want %0d",
                                    out_pair_o.run_value, want.run_value));
          if (out_pair_o.chunk_done !== want.chunk_done)
            flag_mismatch($sformatf("chunk_done got %0b want %0b",
                                    out_pair_o.chunk_done, want.chunk_done));
        end
      end
      if (in_valid_i && in_ready_o) begin
        fold_pixel(in_req_i);
      end
    end
  end

  // End the run when neither channel moves for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_pending) begin
        // hold off long enough for the result queue and input register to fill
        long_hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (stall_en && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 17);
        out_ready_i <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one request at the falling edge, maybe after a gap, and hold it
  // until the encoder takes it. Valid stays high on return so back-to-back
  // requests never drop it in between.
  task automatic send_pixel(logic [7:0] value, logic last);
    int unsigned gap;
    @(negedge clk_i);
    if (gap_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{pixel_value: value, chunk_end: last};
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  // Send count copies of one byte, optionally ending the chunk on the last.
  task automatic send_run(logic [7:0] value, int unsigned count, logic end_chunk);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(value, end_chunk && (i == count - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One-byte chunks: each emits its run of one at once, marked done.
  task automatic test_single_byte_chunks();
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hA5, 1'b1);
  endtask

  // Equal bytes lengthen the run; a chunk end on an equal byte merges first.
  task automatic test_run_merging();
    send_run(8'd7, 3, 1'b0);
    send_run(8'd8, 2, 1'b1);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'hAA, 1'b1);
  endtask

  // A chunk end that breaks the open run emits two pairs.
  task automatic test_chunk_end_break();
    send_run(8'd3, 2, 1'b0);
    send_pixel(8'd9, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
  endtask

  // Full runs: a 255-byte run ends cleanly, one more equal byte splits it.
  task automatic test_full_runs();
    logic [7:0] value;
    value = 8'($urandom_range(0, 255));
    send_run(value, 255, 1'b1);
    send_run(value, 256, 1'b1);
    send_run(value, 300, 1'b0);
    send_pixel(~value, 1'b1);
  endtask

  // Random chunks, mostly short, with runs made likely by reusing the last
  // byte; sometimes flip a single bit to land next to the held value.
  task automatic test_random_chunks(int unsigned target);
    int unsigned len;
    int unsigned pick;
    logic [7:0]  value;
    value = 8'($urandom_range(0, 255));
    while (pixels_sent < target) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 6) begin
          value = value ^ (8'd1 << $urandom_range(0, 7));
        end else if (pick > 6) begin
          value = 8'($urandom_range(0, 255));
        end
        send_pixel(value, i == len - 1);
      end
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    gap_en = 1'b0;
    long_hold_pending = 1'b1;
    test_random_chunks(pixels_sent + 100);
    gap_en = 1'b1;
  endtask

  // Finish on a stream with no idling on either side.
  task automatic test_steady_stream();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    test_random_chunks(pixels_sent + 250);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    in_req_i          = '0;
    run_open_q        = 1'b0;
    held_value_q      = 8'd0;
    held_count_q      = 8'd0;
    mismatch_count    = 0;
    pixels_sent       = 0;
    gap_en            = 1'b1;
    stall_en          = 1'b1;
    long_hold_pending = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_byte_chunks();
    test_run_merging();
    test_chunk_end_break();
    test_full_runs();
    test_random_chunks(1500);
    test_output_backpressure();
    test_steady_stream();

    // Drop valid, drain what is still owed, then watch for stray pairs.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
